### hdl/mac_label_dominance_check_top_macros.svh
// assertion macros for the label dominance check
`ifndef MAC_LABEL_DOMINANCE_CHECK_TOP_MACROS_SVH
`define MAC_LABEL_DOMINANCE_CHECK_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mldc check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define MLDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mldc check failed: next-cycle implication");

`endif

### hdl/mldc_pkg.sv
// shared types and constants of the label dominance check
`timescale 1ns / 1ps
`default_nettype none

package mldc_pkg;

	localparam int CLS_W  = 16;
	localparam int IDX_W  = 10;
	localparam int BITS_W = 32;

	// default depth of the stored label A chunk list
	localparam int DEF_MAX_CHUNKS = 32;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// item kinds decided by the front
	localparam logic [1:0] KIND_A_CHUNK = 2'd0;
	localparam logic [1:0] KIND_A_EMPTY = 2'd1;
	localparam logic [1:0] KIND_B_CHUNK = 2'd2;
	localparam logic [1:0] KIND_B_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CLS_W-1:0]  cls;
		logic [IDX_W-1:0]  idx;
		logic [BITS_W-1:0] bits;
		logic              last;
	} q_item_t;

endpackage

`default_nettype wire

### hdl/mldc_front.sv
// front: accepts beats, tags their kind and queues them for the back
`timescale 1ns / 1ps
`default_nettype none

module mldc_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            req_type,
	input  wire  [mldc_pkg::CLS_W-1:0]     classification,
	input  wire  [mldc_pkg::IDX_W-1:0]     chunk_index,
	input  wire  [mldc_pkg::BITS_W-1:0]    chunk_bits,
	input  wire                            last_entry,
	output logic                           q_valid,
	output mldc_pkg::q_item_t              q_item,
	input  wire                            q_pop
);
	import mldc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	q_item_t         fifo_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	q_item_t         new_item;
	logic            push;

	// classify the incoming beat
	always_comb begin
		new_item.cls  = classification;
		new_item.idx  = chunk_index;
		new_item.bits = chunk_bits;
		new_item.last = last_entry;
		if (req_type) begin
			new_item.kind = (chunk_index == '0) ? KIND_B_EMPTY : KIND_B_CHUNK;
		end else begin
			new_item.kind = (chunk_index == '0) ? KIND_A_EMPTY : KIND_A_CHUNK;
		end
	end

	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/mldc_back.sv
// back: stores label A chunks and merges label B chunks against them
`timescale 1ns / 1ps
`default_nettype none

module mldc_back #(
	parameter int MAX_CHUNKS = mldc_pkg::DEF_MAX_CHUNKS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	input  wire mldc_pkg::q_item_t q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   dominates
);
	import mldc_pkg::*;

	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CW = $clog2(MAX_CHUNKS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [IDX_W+BITS_W-1:0] store_q [MAX_CHUNKS];
	logic [IDX_W+BITS_W-1:0] rd_data_q;
	logic [1:0]              state_q;
	logic [CLS_W-1:0]        first_class_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           ptr_q;
	logic                    failed_q;
	logic                    closed_q;
	logic [IDX_W-1:0]        cur_idx_q;
	logic [BITS_W-1:0]       cur_bits_q;
	logic                    cur_last_q;
	logic                    out_valid_q;
	logic                    dominates_q;

	logic [CW-1:0]           count_eff;
	logic                    wr_en;
	logic                    fail_now;
	logic                    hit;
	logic [IDX_W-1:0]        rd_idx;
	logic [BITS_W-1:0]       rd_bits;
	logic                    out_free;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign count_eff = closed_q ? '0 : count_q;
	assign wr_en     = q_pop && (q_item.kind == KIND_A_CHUNK)
		&& (count_eff < CW'(MAX_CHUNKS));
	assign fail_now  = failed_q || (q_item.cls > first_class_q);
	assign rd_idx    = rd_data_q[IDX_W+BITS_W-1:BITS_W];
	assign rd_bits   = rd_data_q[BITS_W-1:0];
	assign hit       = (ptr_q < count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign dominates = dominates_q;

	// chunk store, read at the merge pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[count_eff[AW-1:0]] <= {q_item.idx, q_item.bits};
		end
		rd_data_q <= store_q[ptr_q[AW-1:0]];
	end

	// last popped beat, held as the current B beat
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_idx_q  <= q_item.idx;
			cur_bits_q <= q_item.bits;
			cur_last_q <= q_item.last;
		end
	end

	// load, merge and result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			first_class_q <= '0;
			count_q       <= '0;
			ptr_q         <= '0;
			failed_q      <= 1'b0;
			closed_q      <= 1'b1;
			out_valid_q   <= 1'b0;
			dominates_q   <= 1'b0;
		end else begin
			// result register: load on a free slot, drop once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.kind)
							KIND_A_CHUNK, KIND_A_EMPTY: begin
								if (closed_q) begin
									ptr_q    <= '0;
									failed_q <= 1'b0;
								end
								first_class_q <= q_item.cls;
								count_q       <= wr_en ? count_eff + 1'b1 : count_eff;
								closed_q      <= q_item.last;
							end
							KIND_B_CHUNK, KIND_B_EMPTY: begin
								failed_q <= fail_now;
								if (q_item.kind == KIND_B_CHUNK && !fail_now) begin
									state_q <= ST_WAIT;
								end else if (q_item.last) begin
									state_q <= ST_FIN;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WAIT: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit && rd_idx < cur_idx_q) begin
						// skip a smaller stored chunk
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_WAIT;
					end else begin
						if (hit && rd_idx == cur_idx_q && (cur_bits_q & ~rd_bits) == '0) begin
							ptr_q <= ptr_q + 1'b1;
						end else begin
							failed_q <= 1'b1;
						end
						state_q <= cur_last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						dominates_q <= !failed_q;
						ptr_q       <= '0;
						failed_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/mac_label_dominance_check_top.sv
// top level of the label dominance check
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid / in_stall | req_type classification chunk_index
//          |           |                     | chunk_bits last_entry
//  out     | output    | out_valid/out_stall | dominates
//
// a beat enters a four-entry queue; the back drains it one beat at a time
// label A beat: handled in the idle state; label B chunk beat not yet failed: wait,
// then compare, repeated per stored A chunk skipped, for the registered store read
// after the last B beat the finish state loads the result register
// reset clears the queue, counters and flags; the chunk store is not cleared
// a stalled result holds the back; the queue still takes beats until full
`timescale 1ns / 1ps
`default_nettype none
`include "mac_label_dominance_check_top_macros.svh"

module mac_label_dominance_check_top #(
	parameter int MAX_CHUNKS = mldc_pkg::DEF_MAX_CHUNKS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            req_type,
	input  wire  [mldc_pkg::CLS_W-1:0]     classification,
	input  wire  [mldc_pkg::IDX_W-1:0]     chunk_index,
	input  wire  [mldc_pkg::BITS_W-1:0]    chunk_bits,
	input  wire                            last_entry,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           dominates
);
	import mldc_pkg::*;

	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;

	// front: accept and tag
	mldc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.classification (classification),
		.chunk_index    (chunk_index),
		.chunk_bits     (chunk_bits),
		.last_entry     (last_entry),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	// back: store and merge
	mldc_back #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dominates (dominates)
	);

	// the back never pops an empty queue
	`MLDC_ASSERT_NOW(a_pop_needs_item, clk, arst_n, q_pop, q_valid)

	// an accepted beat is waiting in the queue on the next cycle
	`MLDC_ASSERT_NEXT(a_accept_fills_queue, clk, arst_n, in_valid && !in_stall, q_valid)

endmodule

`default_nettype wire

### test/tb.sv
// self-checking testbench for the label dominance check
`timescale 1ns / 1ps

module tb;

	import mldc_pkg::CLS_W;
	import mldc_pkg::IDX_W;
	import mldc_pkg::BITS_W;

	localparam int MAX_CHUNKS  = mldc_pkg::DEF_MAX_CHUNKS;
	localparam int ITEM_TARGET = 750;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 20;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		bit              req;
		bit [CLS_W-1:0]  cls;
		bit [IDX_W-1:0]  idx;
		bit [BITS_W-1:0] bits;
		bit              last;
	} beat_t;

	typedef enum int {
		B_GOOD,
		B_WORD_OVER,
		B_CLASS_OVER,
		B_STRAY_INDEX,
		B_SWAPPED,
		B_BARE
	} b_flavor_e;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	wire               in_stall;
	logic              req_type = 1'b0;
	logic [CLS_W-1:0]  classification = '0;
	logic [IDX_W-1:0]  chunk_index = '0;
	logic [BITS_W-1:0] chunk_bits = '0;
	logic              last_entry = 1'b0;
	wire               out_valid;
	logic              out_stall = 1'b0;
	wire               dominates;

	mac_label_dominance_check_top #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.classification(classification),
		.chunk_index(chunk_index),
		.chunk_bits(chunk_bits),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dominates(dominates)
	);

	always #5 clk = ~clk;

	// pending beats and expected verdicts
	beat_t beat_q[$];
	bit    dom_expect[$];

	// label A as generated, used to derive B labels
	bit [CLS_W-1:0]  gen_a_cls;
	bit [IDX_W-1:0]  gen_a_idx[$];
	bit [BITS_W-1:0] gen_a_word[$];

	// predictor state
	bit [CLS_W-1:0]  a_class = '0;
	bit [IDX_W-1:0]  a_idx[MAX_CHUNKS];
	bit [BITS_W-1:0] a_word[MAX_CHUNKS];
	int              a_count = 0;
	int              walk_ptr = 0;
	bit              b_failed = 1'b0;
	bit              a_done = 1'b1;

	int errors = 0;
	int results_got = 0;
	int idle_cycles = 0;
	bit in_took = 1'b0;
	int send_gap = 0;
	int send_calm = 0;

	// verdict prediction for one accepted beat
	task automatic track_beat(input beat_t b);
		if (!b.req) begin
			if (a_done) begin
				a_count = 0;
				walk_ptr = 0;
				b_failed = 1'b0;
				a_done = 1'b0;
			end
			a_class = b.cls;
			if (b.idx != 0 && a_count < MAX_CHUNKS) begin
				a_idx[a_count] = b.idx;
				a_word[a_count] = b.bits;
				a_count++;
			end
			if (b.last)
				a_done = 1'b1;
		end else begin
			if (b.cls > a_class)
				b_failed = 1'b1;
			if (!b_failed && b.idx != 0) begin
				while (walk_ptr < a_count && a_idx[walk_ptr] < b.idx)
					walk_ptr++;
				if (walk_ptr < a_count && a_idx[walk_ptr] == b.idx &&
						(b.bits & ~a_word[walk_ptr]) == 0)
					walk_ptr++;
				else
					b_failed = 1'b1;
			end
			if (b.last) begin
				dom_expect.push_back(!b_failed);
				walk_ptr = 0;
				b_failed = 1'b0;
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic push_beat(input bit req, input bit [CLS_W-1:0] cls,
			input bit [IDX_W-1:0] idx, input bit [BITS_W-1:0] bits, input bit last);
		beat_t b;
		b.req = req;
		b.cls = cls;
		b.idx = idx;
		b.bits = bits;
		b.last = last;
		beat_q.push_back(b);
	endtask

	// label A with n chunks at distinct ascending indices
	task automatic gen_label_a(input int n);
		bit taken[1024];
		int cnt;
		int v;
		bit [CLS_W-1:0] cls;
		cls = CLS_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			cls = CLS_W'($urandom_range(0, 3));
		foreach (taken[i])
			taken[i] = 1'b0;
		cnt = 0;
		while (cnt < n) begin
			v = $urandom_range(1, 1023);
			if (!taken[v]) begin
				taken[v] = 1'b1;
				cnt++;
			end
		end
		gen_a_cls = cls;
		gen_a_idx.delete();
		gen_a_word.delete();
		for (int i = 1; i < 1024; i++) begin
			if (taken[i]) begin
				gen_a_idx.push_back(IDX_W'(i));
				gen_a_word.push_back($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
			end
		end
		if (n == 0) begin
			push_beat(1'b0, cls, '0, $urandom, 1'b1);
		end else begin
			bit tail_empty;
			tail_empty = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 7) == 0)
					push_beat(1'b0, cls, '0, $urandom, 1'b0);
				push_beat(1'b0, cls, gen_a_idx[i], gen_a_word[i], !tail_empty && i == n - 1);
			end
			if (tail_empty)
				push_beat(1'b0, cls, '0, $urandom, 1'b1);
		end
	endtask

	// label B derived from the last label A, spoiled as the flavor asks
	task automatic gen_label_b(input b_flavor_e flavor);
		bit [IDX_W-1:0]  bi[$];
		bit [BITS_W-1:0] bw[$];
		beat_t           lb[$];
		beat_t           b;
		bit [CLS_W-1:0]  cls;
		int k;
		int j;
		int v;
		bit clash;
		cls = CLS_W'($urandom_range(0, gen_a_cls));
		foreach (gen_a_idx[i]) begin
			if ($urandom_range(0, 1) == 0) begin
				bi.push_back(gen_a_idx[i]);
				bw.push_back(gen_a_word[i] & $urandom);
			end
		end
		case (flavor)
			B_WORD_OVER: begin
				if (bi.size() > 0) begin
					k = $urandom_range(0, bi.size() - 1);
					bw[k] = bw[k] | $urandom;
				end else if (gen_a_idx.size() > 0) begin
					bi.push_back(gen_a_idx[0]);
					bw.push_back(32'hFFFF_FFFF);
				end
			end
			B_STRAY_INDEX: begin
				do begin
					v = $urandom_range(1, 1023);
					clash = 1'b0;
					foreach (gen_a_idx[i])
						if (gen_a_idx[i] == v)
							clash = 1'b1;
				end while (clash);
				j = 0;
				while (j < bi.size() && bi[j] < v)
					j++;
				bi.insert(j, IDX_W'(v));
				bw.insert(j, $urandom);
			end
			B_SWAPPED: begin
				if (bi.size() >= 2) begin
					bit [IDX_W-1:0]  ti;
					bit [BITS_W-1:0] tw;
					k = $urandom_range(0, bi.size() - 2);
					j = $urandom_range(k + 1, bi.size() - 1);
					ti = bi[k];
					bi[k] = bi[j];
					bi[j] = ti;
					tw = bw[k];
					bw[k] = bw[j];
					bw[j] = tw;
				end
			end
			B_BARE: begin
				bi.delete();
				bw.delete();
			end
			default: ;
		endcase
		// build the beats, with an occasional beat that carries no chunk
		b.req = 1'b1;
		b.cls = cls;
		b.last = 1'b0;
		foreach (bi[i]) begin
			if ($urandom_range(0, 7) == 0) begin
				b.idx = '0;
				b.bits = $urandom;
				lb.push_back(b);
			end
			b.idx = bi[i];
			b.bits = bw[i];
			lb.push_back(b);
		end
		if (lb.size() == 0 || $urandom_range(0, 4) == 0) begin
			b.idx = '0;
			b.bits = $urandom;
			lb.push_back(b);
		end
		lb[lb.size() - 1].last = 1'b1;
		// class above A on one beat
		if (flavor == B_CLASS_OVER && gen_a_cls != 16'hFFFF) begin
			k = $urandom_range(0, lb.size() - 1);
			lb[k].cls = CLS_W'($urandom_range(gen_a_cls + 1, 16'hFFFF));
		end
		foreach (lb[i])
			beat_q.push_back(lb[i]);
	endtask

	task automatic fill_directed();
		// check before any label A: no chunks stored and class zero
		push_beat(1'b1, 16'h0000, 10'd5, 32'h0000_0001, 1'b1);
		push_beat(1'b1, 16'h0000, 10'd0, 32'h0000_0000, 1'b1);
		// extreme classes, indices and words
		push_beat(1'b0, 16'hFFFF, 10'd1, 32'hFFFF_FFFF, 1'b0);
		push_beat(1'b0, 16'hFFFF, 10'd1023, 32'h0000_0001, 1'b0);
		push_beat(1'b0, 16'hFFFF, 10'd0, 32'h0000_0000, 1'b1);
		push_beat(1'b1, 16'hFFFF, 10'd1, 32'hFFFF_FFFF, 1'b0);
		push_beat(1'b1, 16'hFFFF, 10'd1023, 32'h0000_0001, 1'b1);
		push_beat(1'b1, 16'h0000, 10'd1023, 32'h0000_0002, 1'b1);
		push_beat(1'b1, 16'h0000, 10'd0, 32'hFFFF_FFFF, 1'b1);
		// empty label A, then B class above and equal
		push_beat(1'b0, 16'h0000, 10'd0, 32'h1234_5678, 1'b1);
		push_beat(1'b1, 16'h0001, 10'd0, 32'h0000_0000, 1'b1);
		push_beat(1'b1, 16'h0000, 10'd0, 32'h0000_0000, 1'b1);
		// out-of-order chunks and a missing index
		push_beat(1'b0, 16'd100, 10'd10, 32'h0000_00F0, 1'b0);
		push_beat(1'b0, 16'd100, 10'd20, 32'h0000_000F, 1'b1);
		push_beat(1'b1, 16'd100, 10'd20, 32'h0000_0001, 1'b0);
		push_beat(1'b1, 16'd100, 10'd10, 32'h0000_0010, 1'b1);
		push_beat(1'b1, 16'd99, 10'd15, 32'h0000_0000, 1'b1);
		push_beat(1'b1, 16'd100, 10'd10, 32'h0000_0080, 1'b0);
		push_beat(1'b1, 16'd100, 10'd20, 32'h0000_000F, 1'b1);
		// partial check dropped by the start of a new label A
		push_beat(1'b1, 16'd100, 10'd10, 32'h0000_0010, 1'b0);
		push_beat(1'b0, 16'd50, 10'd7, 32'h0000_0000, 1'b1);
		push_beat(1'b1, 16'd50, 10'd7, 32'h0000_0000, 1'b1);
	endtask

	task automatic fill_random();
		int r;
		int n;
		int nb;
		b_flavor_e fl;
		while (beat_q.size() < ITEM_TARGET - 20) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// noise: fully random beats
				nb = $urandom_range(1, 6);
				repeat (nb)
					push_beat(1'($urandom_range(0, 1)), CLS_W'($urandom),
						$urandom_range(0, 3) == 0 ? 10'd0 : 10'($urandom),
						$urandom, 1'($urandom_range(0, 1)));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8)
					n = 0;
				else if (r < 15)
					n = $urandom_range(MAX_CHUNKS - 1, MAX_CHUNKS + 8);
				else
					n = $urandom_range(1, 6);
				gen_label_a(n);
				nb = $urandom_range(1, 4);
				repeat (nb) begin
					r = $urandom_range(0, 99);
					if (r < 40)
						fl = B_GOOD;
					else if (r < 52)
						fl = B_WORD_OVER;
					else if (r < 64)
						fl = B_CLASS_OVER;
					else if (r < 76)
						fl = B_STRAY_INDEX;
					else if (r < 88)
						fl = B_SWAPPED;
					else
						fl = B_BARE;
					gen_label_b(fl);
				end
			end
		end
	endtask

	// monitor: checks results, predicts on accepted beats, watchdog
	always @(posedge clk) begin
		bit exp_dom;
		bit any_beat;
		beat_t b;
		in_took = 1'b0;
		if (arst_n) begin
			any_beat = 1'b0;
			if (out_valid && !out_stall) begin
				any_beat = 1'b1;
				results_got++;
				if (dom_expect.size() == 0) begin
					$error("dominates: expected nothing, actual %0b", dominates);
					errors++;
				end else begin
					exp_dom = dom_expect.pop_front();
					if (dominates !== exp_dom) begin
						$error("dominates: expected %0b, actual %0b", exp_dom, dominates);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				any_beat = 1'b1;
				in_took = 1'b1;
				b.req = req_type;
				b.cls = classification;
				b.idx = chunk_index;
				b.bits = chunk_bits;
				b.last = last_entry;
				track_beat(b);
			end
			if (any_beat)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// driver: presents queued beats with random gaps
	always @(negedge clk) begin
		beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// stalled beat stays put
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (beat_q.size() > 0) begin
			b = beat_q.pop_front();
			req_type <= b.req;
			classification <= b.cls;
			chunk_index <= b.idx;
			chunk_bits <= b.bits;
			last_entry <= b.last;
			in_valid <= 1'b1;
			send_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: random stalls plus one long hold-off to fill the block
	int  recv_run = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_got >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (recv_run > 0) begin
			recv_run--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			recv_run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
			recv_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 19);
		end
	end

	// stimulus, reset and end of run
	initial begin
		fill_directed();
		fill_random();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (beat_q.size() > 0 || in_valid)
			@(posedge clk);
		while (dom_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (dom_expect.size() > 0) begin
			$error("dominates: %0d expected results never arrived", dom_expect.size());
			errors++;
		end
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### mac_label_dominance_check_top.f
+incdir+hdl
hdl/mldc_pkg.sv
hdl/mldc_front.sv
hdl/mldc_back.sv
hdl/mac_label_dominance_check_top.sv
test/tb.sv
